### hw/rtl/lpws_pkg.sv
package lpws_pkg;

    localparam int COLOR_CHANNELS   = 3;
    localparam int BITS_PER_CHANNEL = 8;
    localparam int MAX_CHANNELS     = 4;
    localparam int FRAME_BITS       = COLOR_CHANNELS * BITS_PER_CHANNEL;
    localparam int BIT_POS_W        = $clog2(FRAME_BITS);
    localparam int TICK_W           = 10;
    localparam int LATCH_W          = 16;
    localparam int COUNT_W          = 16;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int IN_TDATA_W       = 24;
    localparam int OUT_TDATA_W      = 8;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TICK_W-1:0]  ZERO_HIGH_RST = TICK_W'(64);
    localparam logic [TICK_W-1:0]  ZERO_LOW_RST  = TICK_W'(136);
    localparam logic [TICK_W-1:0]  ONE_HIGH_RST  = TICK_W'(128);
    localparam logic [TICK_W-1:0]  ONE_LOW_RST   = TICK_W'(72);
    localparam logic [LATCH_W-1:0] LATCH_RST     = LATCH_W'(48000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_ENABLE = 3'd0,
        REG_ZERO_HIGH   = 3'd1,
        REG_ZERO_LOW    = 3'd2,
        REG_ONE_HIGH    = 3'd3,
        REG_ONE_LOW     = 3'd4,
        REG_LATCH       = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef struct packed {
        logic               line_enable;
        logic [TICK_W-1:0]  zero_high_ticks;
        logic [TICK_W-1:0]  zero_low_ticks;
        logic [TICK_W-1:0]  one_high_ticks;
        logic [TICK_W-1:0]  one_low_ticks;
        logic [LATCH_W-1:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [FRAME_BITS-1:0] frame;
    } item_t;

    typedef struct packed {
        logic load_dropped;
        logic load_taken;
        logic busy_res;
        logic line_level;
    } result_t;

    function automatic logic [FRAME_BITS-1:0] pack_frame(
        input logic [BITS_PER_CHANNEL-1:0] red,
        input logic [BITS_PER_CHANNEL-1:0] green,
        input logic [BITS_PER_CHANNEL-1:0] blue
    );
        logic [BITS_PER_CHANNEL-1:0] ch [MAX_CHANNELS];
        logic [FRAME_BITS-1:0]       f;
        ch[0] = red;
        ch[1] = green;
        ch[2] = blue;
        ch[3] = '0;
        f = '0;
        for (int c = 0; c < COLOR_CHANNELS; c++)
        begin
            f = (f << BITS_PER_CHANNEL) | FRAME_BITS'(ch[c]);
        end
        return f;
    endfunction

endpackage

### hw/rtl/led_pulse_width_serializer_unit.sv
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: red, green, blue; tuser: op (0 tick, 1 load)
// m_*       out  m_tvalid/m_tready   tdata: line_level, busy_res, load_taken, load_dropped
// cfg_*     in   cfg_wr_en           cfg_index selects register, cfg_data value
//
// One word in and one word out per clock while neither side stalls.
// Each word passes through the input register, a four-entry queue and the output register.
// Reset clears the line state, the queue and the registers to their defaults.
// Either side may stall; six words (four in the queue) are held before s_tready falls.
module led_pulse_width_serializer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpws_pkg::IN_TDATA_W-1:0]      s_tdata,   // red, green, blue
    input  logic                                 s_tuser,   // op
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lpws_pkg::OUT_TDATA_W-1:0]     m_tdata,   // line_level, busy_res,
                                                            // load_taken, load_dropped
    input  logic                                 cfg_wr_en,
    input  logic [lpws_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lpws_pkg::CFG_DATA_W-1:0]      cfg_data
);

    lpws_pkg::cfg_t  cfg_reg;
    lpws_pkg::item_t front_item;
    lpws_pkg::item_t queue_item;
    logic            front_valid;
    logic            front_ready;
    logic            queue_valid;
    logic            queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_enable     <= 1'b0;
            cfg_reg.zero_high_ticks <= lpws_pkg::ZERO_HIGH_RST;
            cfg_reg.zero_low_ticks  <= lpws_pkg::ZERO_LOW_RST;
            cfg_reg.one_high_ticks  <= lpws_pkg::ONE_HIGH_RST;
            cfg_reg.one_low_ticks   <= lpws_pkg::ONE_LOW_RST;
            cfg_reg.latch_ticks     <= lpws_pkg::LATCH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (lpws_pkg::cfg_reg_t'(cfg_index))
                lpws_pkg::REG_LINE_ENABLE: cfg_reg.line_enable <= cfg_data[0];
                lpws_pkg::REG_ZERO_HIGH:
                    cfg_reg.zero_high_ticks <= cfg_data[lpws_pkg::TICK_W-1:0];
                lpws_pkg::REG_ZERO_LOW:
                    cfg_reg.zero_low_ticks <= cfg_data[lpws_pkg::TICK_W-1:0];
                lpws_pkg::REG_ONE_HIGH:
                    cfg_reg.one_high_ticks <= cfg_data[lpws_pkg::TICK_W-1:0];
                lpws_pkg::REG_ONE_LOW:
                    cfg_reg.one_low_ticks <= cfg_data[lpws_pkg::TICK_W-1:0];
                lpws_pkg::REG_LATCH:
                    cfg_reg.latch_ticks <= cfg_data[lpws_pkg::LATCH_W-1:0];
                default: ;
            endcase
        end
    end

    lpws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    lpws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    lpws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### hw/rtl/lpws_front.sv
module lpws_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lpws_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    output logic                               item_valid,
    input  logic                               item_ready,
    output lpws_pkg::item_t                    item
);

    logic            valid_reg;
    lpws_pkg::item_t item_reg;
    lpws_pkg::item_t item_next;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // classify and pack the color frame
    always_comb
    begin
        item_next.op    = lpws_pkg::op_t'(s_tuser);
        item_next.frame = lpws_pkg::pack_frame(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/lpws_queue.sv
module lpws_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  lpws_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output lpws_pkg::item_t rd_item
);

    lpws_pkg::item_t                    mem [lpws_pkg::QUEUE_DEPTH];
    logic [lpws_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [lpws_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [lpws_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic                               push;
    logic                               pop;

    assign wr_ready = count_reg != lpws_pkg::QUEUE_CNT_W'(lpws_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hw/rtl/lpws_back.sv
module lpws_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpws_pkg::cfg_t                      cfg,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  lpws_pkg::item_t                     item,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpws_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    phase_t                               phase_reg, phase_next, phase_eff;
    logic [lpws_pkg::BIT_POS_W-1:0]       bit_pos_reg, bit_pos_next, bit_pos_eff;
    logic [lpws_pkg::COUNT_W-1:0]         count_reg, count_next, count_eff, count_inc;
    logic [lpws_pkg::FRAME_BITS-1:0]      frame_reg, frame_next, frame_eff;
    logic [lpws_pkg::COUNT_W-1:0]         phase_len;
    logic                                 cur_bit;
    logic                                 pop;
    logic                                 m_valid_reg;
    lpws_pkg::result_t                    res_reg, res_next;

    assign item_ready = !m_valid_reg || m_tready;
    assign pop        = item_valid && item_ready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = lpws_pkg::OUT_TDATA_W'(res_reg);

    always_comb
    begin
        // a disabled line drops back to idle on the next word
        phase_eff   = cfg.line_enable ? phase_reg : PH_IDLE;
        bit_pos_eff = cfg.line_enable ? bit_pos_reg : '0;
        count_eff   = cfg.line_enable ? count_reg : '0;
        frame_eff   = cfg.line_enable ? frame_reg : '0;
        cur_bit     = frame_eff[lpws_pkg::FRAME_BITS-1];
        count_inc   = count_eff + 1'b1;

        unique case (phase_eff)
            PH_HIGH:  phase_len = lpws_pkg::COUNT_W'(cur_bit ? cfg.one_high_ticks
                                                             : cfg.zero_high_ticks);
            PH_LOW:   phase_len = lpws_pkg::COUNT_W'(cur_bit ? cfg.one_low_ticks
                                                             : cfg.zero_low_ticks);
            default:  phase_len = cfg.latch_ticks;
        endcase

        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        count_next   = count_reg;
        frame_next   = frame_reg;

        res_next.line_level   = cfg.line_enable && (phase_reg == PH_HIGH);
        res_next.load_taken   = 1'b0;
        res_next.load_dropped = 1'b0;

        if (pop)
        begin
            phase_next   = phase_eff;
            bit_pos_next = bit_pos_eff;
            count_next   = count_eff;
            frame_next   = frame_eff;

            if (item.op == lpws_pkg::OP_LOAD)
            begin
                if (!cfg.line_enable || phase_eff != PH_IDLE)
                begin
                    res_next.load_dropped = 1'b1;
                end
                else
                begin
                    frame_next          = item.frame;
                    bit_pos_next        = '0;
                    count_next          = '0;
                    phase_next          = PH_HIGH;
                    res_next.load_taken = 1'b1;
                end
            end
            else if (phase_eff != PH_IDLE)
            begin
                if (count_inc != '0 && count_inc < phase_len)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    count_next = '0;
                    unique case (phase_eff)
                        PH_HIGH:
                        begin
                            phase_next = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            if (bit_pos_eff ==
                                lpws_pkg::BIT_POS_W'(lpws_pkg::FRAME_BITS - 1))
                            begin
                                phase_next = PH_LATCH;
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_eff + 1'b1;
                                frame_next   = frame_eff << 1;
                                phase_next   = PH_HIGH;
                            end
                        end
                        default:
                        begin
                            phase_next   = PH_IDLE;
                            bit_pos_next = '0;
                            frame_next   = '0;
                        end
                    endcase
                end
            end
        end

        res_next.busy_res = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_pos_reg <= '0;
            count_reg   <= '0;
            frame_reg   <= '0;
            m_valid_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            count_reg   <= count_next;
            frame_reg   <= frame_next;
            if (pop)
            begin
                m_valid_reg <= 1'b1;
                res_reg     <= res_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import lpws_pkg::*;

    typedef struct packed {
        op_t        op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } led_word_t;

    typedef enum logic [1:0] {
        LINE_IDLE  = 2'd0,
        LINE_HIGH  = 2'd1,
        LINE_LOW   = 2'd2,
        LINE_LATCH = 2'd3
    } line_phase_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    led_word_t pending_words [$];
    result_t   due_results [$];
    led_word_t word_on_bus;
    result_t   outcome;
    result_t   got;
    result_t   want;

    cfg_t                  line_cfg;
    line_phase_t           line_phase;
    int                    line_pos;
    logic [COUNT_W-1:0]    line_count;
    logic [FRAME_BITS-1:0] line_shift;

    int tx_gap, tx_calm, rx_stall, rx_calm;
    int error_count, words_in, loads_taken, loads_dropped, results_seen;
    int settings_used, queued_words, burst_end;
    logic [FRAME_BITS-1:0] frame_bits;

    led_pulse_width_serializer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_line();
        line_phase = LINE_IDLE;
        line_pos   = 0;
        line_count = '0;
        line_shift = '0;
    endfunction

    function automatic int at_least_one(int unsigned v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    function automatic result_t step_line(led_word_t w);
        result_t     r;
        logic        b;
        int unsigned span;
        r = '0;
        if (!line_cfg.line_enable)
            clear_line();
        r.line_level = line_cfg.line_enable && (line_phase == LINE_HIGH);
        if (w.op == OP_LOAD)
        begin
            if (!line_cfg.line_enable || line_phase != LINE_IDLE)
                r.load_dropped = 1'b1;
            else
            begin
                line_shift   = {w.red, w.green, w.blue};
                line_pos     = 0;
                line_count   = '0;
                line_phase   = LINE_HIGH;
                r.load_taken = 1'b1;
            end
        end
        else if (line_phase != LINE_IDLE)
        begin
            line_count = line_count + 1'b1;
            b = (line_pos < FRAME_BITS) ? line_shift[FRAME_BITS-1-line_pos] : 1'b0;
            case (line_phase)
                LINE_HIGH: span = b ? line_cfg.one_high_ticks : line_cfg.zero_high_ticks;
                LINE_LOW:  span = b ? line_cfg.one_low_ticks : line_cfg.zero_low_ticks;
                default:   span = line_cfg.latch_ticks;
            endcase
            if (line_count == 0 || line_count >= span)
            begin
                line_count = '0;
                case (line_phase)
                    LINE_HIGH: line_phase = LINE_LOW;
                    LINE_LOW:
                    begin
                        if (line_pos + 1 >= FRAME_BITS)
                            line_phase = LINE_LATCH;
                        else
                        begin
                            line_pos   = line_pos + 1;
                            line_phase = LINE_HIGH;
                        end
                    end
                    default: clear_line();
                endcase
            end
        end
        r.busy_res = (line_phase != LINE_IDLE);
        return r;
    endfunction

    function automatic int frame_ticks(logic [FRAME_BITS-1:0] f);
        int   total;
        logic b;
        total = 0;
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            b = f[FRAME_BITS-1-i];
            total += at_least_one(b ? line_cfg.one_high_ticks : line_cfg.zero_high_ticks);
            total += at_least_one(b ? line_cfg.one_low_ticks : line_cfg.zero_low_ticks);
        end
        return total + at_least_one(line_cfg.latch_ticks);
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            calm = $urandom_range(30, 120);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [FRAME_BITS-1:0] pick_frame();
        return {pick_byte(), pick_byte(), pick_byte()};
    endfunction

    task automatic push_word(op_t op, logic [FRAME_BITS-1:0] f);
        led_word_t w;
        w.op    = op;
        w.red   = f[23:16];
        w.green = f[15:8];
        w.blue  = f[7:0];
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic play_frame(logic [FRAME_BITS-1:0] f, int ticks, bit intrude);
        int cut;
        cut = intrude ? $urandom_range(0, ticks - 1) : -1;
        push_word(OP_LOAD, f);
        for (int i = 0; i < ticks; i++)
        begin
            if (i == cut)
                push_word(OP_LOAD, pick_frame());
            push_word(OP_TICK, FRAME_BITS'($urandom));
        end
    endtask

    task automatic drain_all();
        @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // finish any frame in flight so register writes never land mid-frame
    task automatic settle_line();
        drain_all();
        while (line_phase != LINE_IDLE)
        begin
            repeat (16) push_word(OP_TICK, FRAME_BITS'($urandom));
            drain_all();
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case (idx)
            REG_LINE_ENABLE:
            begin
                data[0] = val[0];
                line_cfg.line_enable = val[0];
            end
            REG_ZERO_HIGH:
            begin
                data[TICK_W-1:0] = val[TICK_W-1:0];
                line_cfg.zero_high_ticks = val[TICK_W-1:0];
            end
            REG_ZERO_LOW:
            begin
                data[TICK_W-1:0] = val[TICK_W-1:0];
                line_cfg.zero_low_ticks = val[TICK_W-1:0];
            end
            REG_ONE_HIGH:
            begin
                data[TICK_W-1:0] = val[TICK_W-1:0];
                line_cfg.one_high_ticks = val[TICK_W-1:0];
            end
            REG_ONE_LOW:
            begin
                data[TICK_W-1:0] = val[TICK_W-1:0];
                line_cfg.one_low_ticks = val[TICK_W-1:0];
            end
            default:
            begin
                data = val[LATCH_W-1:0];
                line_cfg.latch_ticks = val[LATCH_W-1:0];
            end
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic set_line(int unsigned en, int unsigned zh, int unsigned zl,
                            int unsigned oh, int unsigned ol, int unsigned latch);
        settle_line();
        write_reg(REG_LINE_ENABLE, en);
        write_reg(REG_ZERO_HIGH, zh);
        write_reg(REG_ZERO_LOW, zl);
        write_reg(REG_ONE_HIGH, oh);
        write_reg(REG_ONE_LOW, ol);
        write_reg(REG_LATCH, latch);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic run_bursts(int budget);
        int len, mode, n;
        burst_end = queued_words + budget;
        while (queued_words < burst_end)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                frame_bits = pick_frame();
                len  = frame_ticks(frame_bits);
                mode = $urandom_range(0, 9);
                if (mode < 6)
                    play_frame(frame_bits, len + $urandom_range(0, 3), 1'b0);
                else if (mode < 8)
                    play_frame(frame_bits, $urandom_range(1, len - 1), 1'b0);
                else
                    play_frame(frame_bits, len + $urandom_range(0, 2), 1'b1);
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_word(op_t'($urandom_range(0, 1)), FRAME_BITS'($urandom));
            end
        end
    endtask

    task automatic report(string name, logic exp_bit, logic act_bit);
        if (exp_bit !== act_bit)
        begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_bit, act_bit);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                outcome = step_line(word_on_bus);
                due_results.push_back(outcome);
                words_in++;
                loads_taken   += outcome.load_taken;
                loads_dropped += outcome.load_dropped;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_tdata  <= {word_on_bus.blue, word_on_bus.green, word_on_bus.red};
                    s_tuser  <= word_on_bus.op;
                    s_tvalid <= 1'b1;
                    tx_gap = pick_gap(tx_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = result_t'(m_tdata[3:0]);
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none got 0x%02h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    report("line_level", want.line_level, got.line_level);
                    report("busy_res", want.busy_res, got.busy_res);
                    report("load_taken", want.load_taken, got.load_taken);
                    report("load_dropped", want.load_dropped, got.load_dropped);
                    if (m_tdata[OUT_TDATA_W-1:4] !== '0)
                    begin
                        $display("%0t: tdata padding mismatch, expected 0 got 0x%0h",
                                 $time, m_tdata[OUT_TDATA_W-1:4]);
                        error_count++;
                    end
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        line_cfg = '{line_enable: 1'b0, zero_high_ticks: ZERO_HIGH_RST,
                     zero_low_ticks: ZERO_LOW_RST, one_high_ticks: ONE_HIGH_RST,
                     one_low_ticks: ONE_LOW_RST, latch_ticks: LATCH_RST};
        clear_line();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // line disabled after reset: every load is refused, line stays low
        push_word(OP_LOAD, 24'h000000);
        push_word(OP_TICK, 24'hFFFFFF);
        push_word(OP_LOAD, 24'hFFFFFF);
        push_word(OP_LOAD, 24'h8001A5);
        push_word(OP_TICK, 24'h000000);
        push_word(OP_LOAD, 24'h5AC33C);

        set_line(1, 1, 1, 1, 1, 1);
        play_frame(24'hFFFFFF, frame_ticks(24'hFFFFFF), 1'b0);
        play_frame(24'h000000, frame_ticks(24'h000000), 1'b1);
        play_frame(24'h8001A5, frame_ticks(24'h8001A5) - 1, 1'b0);
        play_frame(24'h7F0180, 3, 1'b0);
        run_bursts(100);

        // zero counts act as one tick
        set_line(1, 0, 0, 0, 0, 0);
        play_frame(24'hF00F3C, frame_ticks(24'hF00F3C), 1'b0);
        run_bursts(80);

        set_line(1, 1, 3, 3, 1, 5);
        play_frame(24'hFF0000, frame_ticks(24'hFF0000), 1'b0);
        play_frame(24'h00FF00, frame_ticks(24'h00FF00), 1'b0);
        play_frame(24'h0000FF, frame_ticks(24'h0000FF), 1'b0);
        run_bursts(100);

        set_line(1, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                 $urandom_range(1, 4), $urandom_range(1, 12));
        run_bursts(120);

        set_line(1, 1023, 1023, 1023, 1023, 65535);
        frame_bits = pick_frame();
        play_frame(frame_bits, 120, 1'b1);

        // drop the line in the middle of a long frame
        drain_all();
        write_reg(REG_LINE_ENABLE, 0);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        push_word(OP_TICK, 24'h000000);
        push_word(OP_LOAD, 24'hA5A5A5);
        push_word(OP_TICK, 24'hFFFFFF);

        set_line(0, 3, 2, 1, 4, 5);
        run_bursts(60);

        drain_all();
        repeat (10) @(posedge clk);
        $display("Sent %0d words: %0d loads taken, %0d loads refused; %0d results checked",
                 words_in, loads_taken, loads_dropped, results_seen);
        $display("Ran %0d timing settings, from zero and one tick up to the longest phases",
                 settings_used);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
